### hw/rtl/mfhba_pkg.sv
// ----------------------------------------------------------------------------
// mfhba_pkg
// Types, constants and the polynomial lookup shared by the MAC/FID hash
// bucket address block and its CRC cells.
// ----------------------------------------------------------------------------
package mfhba_pkg;

   // Polynomial select codes
   localparam logic [1:0] POLY_SEL_CCITT     = 2'd0;
   localparam logic [1:0] POLY_SEL_IBM       = 2'd1;
   localparam logic [1:0] POLY_SEL_DECT      = 2'd2;
   localparam logic [1:0] POLY_SEL_CCITT_ALT = 2'd3;

   // 20-bit remainder polynomials
   localparam int unsigned REM_W = 20;
   localparam logic [REM_W-1:0] POLY_CCITT = 20'h88108;
   localparam logic [REM_W-1:0] POLY_IBM   = 20'hC0028;
   localparam logic [REM_W-1:0] POLY_DECT  = 20'h82C48;

   // CRC geometry: four 16-bit words, 20 shift steps per word
   localparam int unsigned WORD_W         = 16;
   localparam int unsigned NUM_WORDS      = 4;
   localparam int unsigned WORDS_W        = WORD_W * NUM_WORDS;
   localparam int unsigned STEPS_PER_WORD = 20;
   localparam int unsigned STEPS_PER_CELL = 5;
   localparam int unsigned CELLS_PER_WORD = STEPS_PER_WORD / STEPS_PER_CELL;
   localparam int unsigned NUM_CELLS      = CELLS_PER_WORD * NUM_WORDS;

   // Remainder whose bits 19..4 hold the CRC seed 0xFFFF
   localparam logic [REM_W-1:0] REM_INIT = 20'hFFFF0;

   // Field widths
   localparam int unsigned MAC_HIGH_W = 16;
   localparam int unsigned MAC_LOW_W  = 32;
   localparam int unsigned FID_W      = 8;
   localparam int unsigned BUCKET_W   = 2;
   localparam int unsigned HASH_OUT_W = 11;
   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned ADDR_LSB_W = 3;

   typedef struct packed {
      logic [MAC_HIGH_W-1:0] mac_high;
      logic [MAC_LOW_W-1:0]  mac_low;
      logic [FID_W-1:0]      filter_id;
      logic [BUCKET_W-1:0]   bucket_number;
   } req_type;

   typedef struct packed {
      logic [HASH_OUT_W-1:0] hash_value;
      logic [ADDR_W-1:0]     table_address;
   } rsp_type;

   // Data handed from one CRC cell to the next
   typedef struct packed {
      logic [REM_W-1:0]    rem;
      logic [WORDS_W-1:0]  words;
      logic [BUCKET_W-1:0] bucket;
   } stage_type;

   function automatic logic [REM_W-1:0] poly_of(input logic [1:0] sel);
      logic [REM_W-1:0] p;
      unique case (sel)
         POLY_SEL_CCITT:     p = POLY_CCITT;
         POLY_SEL_IBM:       p = POLY_IBM;
         POLY_SEL_DECT:      p = POLY_DECT;
         POLY_SEL_CCITT_ALT: p = POLY_CCITT;
         default:            p = POLY_CCITT;
      endcase
      return p;
   endfunction

endpackage

### hw/rtl/mac_fid_hash_bucket_address.sv
// Throughput: one transaction per cycle while no response is held under
// rsp_stall; a chain of 16 CRC cells, 5 shift steps each (4 cells per 16-bit
// word), sets the latency.
// The whole chain holds while a response waits under rsp_stall.
// Reset (synchronous, active high) empties the chain and selects CCITT.
// ----------------------------------------------------------------------------
// mac_fid_hash_bucket_address
// Hashes filtering id and MAC address with a selectable CRC-16 and forms
// the hash table bucket address.
// ----------------------------------------------------------------------------
module mac_fid_hash_bucket_address #(
   parameter int unsigned HASH_BITS = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mfhba_pkg::req_type   req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mfhba_pkg::rsp_type   rsp_data,
   // configuration
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_wr_data
);

   logic [1:0]                   poly_select_ff;
   logic [mfhba_pkg::REM_W-1:0]  poly;
   logic                         enable;
   logic                         valid_chain [mfhba_pkg::NUM_CELLS+1];
   mfhba_pkg::stage_type         data_chain  [mfhba_pkg::NUM_CELLS+1];
   logic [HASH_BITS-1:0]         hash;

   // Polynomial select register
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_select_ff <= mfhba_pkg::POLY_SEL_CCITT;
      end else if (csr_wr_en) begin
         poly_select_ff <= csr_wr_data;
      end
   end

   assign poly = mfhba_pkg::poly_of(poly_select_ff);

   // Chain advances unless the last response is held
   assign enable    = !rsp_valid || !rsp_stall;
   assign req_stall = !enable;

   // Chain entry: fid zero-extended first, then MAC high, MAC low halves
   assign valid_chain[0]       = req_valid;
   assign data_chain[0].rem    = mfhba_pkg::REM_INIT;
   assign data_chain[0].words  = {{(mfhba_pkg::WORD_W - mfhba_pkg::FID_W){1'b0}},
                                  req_data.filter_id,
                                  req_data.mac_high,
                                  req_data.mac_low};
   assign data_chain[0].bucket = req_data.bucket_number;

   // Row of CRC cells
   for (genvar k = 0; k < mfhba_pkg::NUM_CELLS; k++) begin : g_cell
      mfhba_cell #(
         .LOAD ((k % mfhba_pkg::CELLS_PER_WORD) == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .poly      (poly),
         .valid_in  (valid_chain[k]),
         .data_in   (data_chain[k]),
         .valid_out (valid_chain[k+1]),
         .data_out  (data_chain[k+1])
      );
   end

   // Response: CRC is remainder bits 19..4, hash its low bits
   assign hash = data_chain[mfhba_pkg::NUM_CELLS]
                    .rem[mfhba_pkg::REM_W-mfhba_pkg::WORD_W +: HASH_BITS];

   assign rsp_valid              = valid_chain[mfhba_pkg::NUM_CELLS];
   assign rsp_data.hash_value    = mfhba_pkg::HASH_OUT_W'(hash);
   assign rsp_data.table_address = mfhba_pkg::ADDR_W'({hash,
                                      data_chain[mfhba_pkg::NUM_CELLS].bucket,
                                      {mfhba_pkg::ADDR_LSB_W{1'b0}}});

endmodule

### hw/rtl/mfhba_cell.sv
// ----------------------------------------------------------------------------
// mfhba_cell
// One CRC cell: optionally folds the next 16-bit word into the remainder,
// runs a few shift steps and registers the result for the next cell.
// ----------------------------------------------------------------------------
module mfhba_cell #(
   parameter bit LOAD = 1'b0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic [mfhba_pkg::REM_W-1:0]         poly,
   input  logic                                valid_in,
   input  mfhba_pkg::stage_type                data_in,
   output logic                                valid_out,
   output mfhba_pkg::stage_type                data_out
);

   logic                  valid_ff;
   mfhba_pkg::stage_type  data_ff;
   mfhba_pkg::stage_type  data_in_c;

   // Word fold (first cell of a word) and shift steps
   always_comb begin
      logic [mfhba_pkg::REM_W-1:0]   rem;
      logic [mfhba_pkg::WORDS_W-1:0] words;
      rem   = data_in.rem;
      words = data_in.words;
      if (LOAD) begin
         // new remainder = word xor current CRC (remainder bits 19..4)
         rem = {{(mfhba_pkg::REM_W - mfhba_pkg::WORD_W){1'b0}},
                words[mfhba_pkg::WORDS_W-1 -: mfhba_pkg::WORD_W]
                ^ data_in.rem[mfhba_pkg::REM_W-1 -: mfhba_pkg::WORD_W]};
         words = {words[mfhba_pkg::WORDS_W-mfhba_pkg::WORD_W-1:0],
                  {mfhba_pkg::WORD_W{1'b0}}};
      end
      for (int i = 0; i < mfhba_pkg::STEPS_PER_CELL; i++) begin
         if (rem[mfhba_pkg::REM_W-1]) begin
            rem = rem ^ poly;
         end
         rem = {rem[mfhba_pkg::REM_W-2:0], 1'b0};
      end
      data_in_c.rem    = rem;
      data_in_c.words  = words;
      data_in_c.bucket = data_in.bucket;
   end

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule
